[design/rpi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rpi_pkg;
    localparam int CW     = 32;          // coordinate width
    localparam int FB     = 16;          // fraction bits
    localparam int PROD_W = 2 * CW;      // d * n
    localparam int DIFF_W = CW + 1;      // p - s
    localparam int PN_W   = DIFF_W + CW; // (p - s) * n
    localparam int DEN_W  = PROD_W + 2;  // sum of three products
    localparam int NUM_W  = PN_W + 2;
    localparam int NMAG_W = NUM_W + FB;  // scaled numerator magnitude
    localparam int REM_W  = DEN_W + CW;  // divisor shifted by up to CW-1, plus guard
    localparam int SUM_W  = PROD_W - FB + 1;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec3;

    // Data that rides along with the quotient
    typedef struct packed {
        logic  hit;
        logic  tneg;
        t_vec3 s;
        t_vec3 d;
    } t_side;
endpackage
`default_nettype wire

[design/rpi_dot.sv]
`timescale 1ns / 1ps
`default_nettype none
module rpi_dot (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_vld,
    input  wire rpi_pkg::t_vec3             i_s,
    input  wire rpi_pkg::t_vec3             i_d,
    input  wire rpi_pkg::t_vec3             i_p,
    input  wire rpi_pkg::t_vec3             i_n,
    output logic                            o_vld,
    output rpi_pkg::t_side                  o_side,
    output logic [rpi_pkg::DEN_W-1:0]       o_dmag,
    output logic [rpi_pkg::NMAG_W-1:0]      o_nmag
);
    import rpi_pkg::*;

    logic                     r_vld1, r_vld2, r_vld3;
    t_vec3                    r_s1, r_d1, r_n1, r_s2, r_d2, r_s3, r_d3;
    logic signed [DIFF_W-1:0] r_df [3];
    logic signed [PROD_W-1:0] r_dn [3];
    logic signed [PN_W-1:0]   r_pn [3];
    logic signed [DEN_W-1:0]  r_den;
    logic signed [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]         n_nabs;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            o_vld  <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            o_vld  <= r_vld3;
        end
    end

    // Stage 1: plane point minus ray start
    always_ff @(posedge i_clk) begin
        r_s1 <= i_s;
        r_d1 <= i_d;
        r_n1 <= i_n;
        r_df[0] <= DIFF_W'(i_p.x) - DIFF_W'(i_s.x);
        r_df[1] <= DIFF_W'(i_p.y) - DIFF_W'(i_s.y);
        r_df[2] <= DIFF_W'(i_p.z) - DIFF_W'(i_s.z);
    end

    // Stage 2: products
    always_ff @(posedge i_clk) begin
        r_s2 <= r_s1;
        r_d2 <= r_d1;
        r_dn[0] <= r_d1.x * r_n1.x;
        r_dn[1] <= r_d1.y * r_n1.y;
        r_dn[2] <= r_d1.z * r_n1.z;
        r_pn[0] <= r_df[0] * PN_W'(r_n1.x);
        r_pn[1] <= r_df[1] * PN_W'(r_n1.y);
        r_pn[2] <= r_df[2] * PN_W'(r_n1.z);
    end

    // Stage 3: sums
    always_ff @(posedge i_clk) begin
        r_s3  <= r_s2;
        r_d3  <= r_d2;
        r_den <= DEN_W'(r_dn[0]) + DEN_W'(r_dn[1]) + DEN_W'(r_dn[2]);
        r_num <= NUM_W'(r_pn[0]) + NUM_W'(r_pn[1]) + NUM_W'(r_pn[2]);
    end

    // Stage 4: magnitudes and sign of t
    assign n_nabs = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);

    always_ff @(posedge i_clk) begin
        o_side.hit  <= r_den[DEN_W-1];
        o_side.tneg <= !r_num[NUM_W-1] && (r_num != '0);
        o_side.s    <= r_s3;
        o_side.d    <= r_d3;
        o_dmag      <= DEN_W'(-r_den);
        o_nmag      <= {n_nabs, FB'(0)};
    end
endmodule
`default_nettype wire

[design/rpi_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module rpi_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_vld,
    input  wire rpi_pkg::t_side             i_side,
    input  wire logic [rpi_pkg::DEN_W-1:0]  i_dmag,
    input  wire logic [rpi_pkg::NMAG_W-1:0] i_nmag,
    output logic                            o_vld,
    output rpi_pkg::t_side                  o_side,
    output logic [rpi_pkg::CW-1:0]          o_q
);
    import rpi_pkg::*;

    // One restoring step per stage, top quotient bit first
    logic             r_vld  [CW];
    t_side            r_side [CW];
    logic [DEN_W-1:0] r_dmag [CW];
    logic [REM_W-1:0] r_rem  [CW];
    logic [CW-1:0]    r_q    [CW];

    for (genvar k = 0; k < CW; k++) begin : g_step
        logic             w_vld;
        t_side            w_side;
        logic [DEN_W-1:0] w_dmag;
        logic [REM_W-1:0] w_rem, w_sub;
        logic [CW-1:0]    w_q;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_side = i_side;
            assign w_dmag = i_dmag;
            assign w_rem  = REM_W'(i_nmag);
            assign w_q    = '0;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_side = r_side[k-1];
            assign w_dmag = r_dmag[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_q    = r_q[k-1];
        end

        assign w_sub = REM_W'(w_dmag) << (CW - 1 - k);
        assign w_ge  = w_rem >= w_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld;
            end
        end

        // Subtract when the shifted divisor fits
        always_ff @(posedge i_clk) begin
            r_side[k] <= w_side;
            r_dmag[k] <= w_dmag;
            r_rem[k]  <= w_ge ? w_rem - w_sub : w_rem;
            r_q[k]    <= {w_q[CW-2:0], w_ge};
        end
    end

    assign o_vld  = r_vld[CW-1];
    assign o_side = r_side[CW-1];
    assign o_q    = r_q[CW-1];
endmodule
`default_nettype wire

[design/rpi_point.sv]
`timescale 1ns / 1ps
`default_nettype none
module rpi_point (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_vld,
    input  wire rpi_pkg::t_side         i_side,
    input  wire logic [rpi_pkg::CW-1:0] i_q,
    output logic                        o_vld,
    output logic                        o_hit,
    output rpi_pkg::t_vec3              o_pt
);
    import rpi_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    logic                     r_vld1, r_vld2;
    logic                     r_hit1, r_hit2;
    t_vec3                    r_s1, r_d1, r_s2;
    t_coord                   r_t;
    logic signed [PROD_W-1:0] r_pr [3];
    logic signed [SUM_W-1:0]  n_sum [3];
    t_coord                   n_c [3];
    logic                     w_ovf;
    t_coord                   w_qs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            o_vld  <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            o_vld  <= r_vld2;
        end
    end

    // Signed, saturated t
    assign w_ovf = i_q[CW-1];
    assign w_qs  = $signed(i_q);

    always_ff @(posedge i_clk) begin
        r_hit1 <= i_side.hit;
        r_s1   <= i_side.s;
        r_d1   <= i_side.d;
        if (w_ovf) begin
            r_t <= i_side.tneg ? t_coord'(SAT_LO) : t_coord'(SAT_HI);
        end else begin
            r_t <= i_side.tneg ? -w_qs : w_qs;
        end
    end

    // Direction times t
    always_ff @(posedge i_clk) begin
        r_hit2 <= r_hit1;
        r_s2   <= r_s1;
        r_pr[0] <= r_d1.x * r_t;
        r_pr[1] <= r_d1.y * r_t;
        r_pr[2] <= r_d1.z * r_t;
    end

    // Add start, floor the shift, saturate
    always_comb begin
        n_sum[0] = SUM_W'(r_s2.x) + SUM_W'(r_pr[0] >>> FB);
        n_sum[1] = SUM_W'(r_s2.y) + SUM_W'(r_pr[1] >>> FB);
        n_sum[2] = SUM_W'(r_s2.z) + SUM_W'(r_pr[2] >>> FB);
        for (int i = 0; i < 3; i++) begin
            if (n_sum[i] > SAT_HI) begin
                n_c[i] = t_coord'(SAT_HI);
            end else if (n_sum[i] < SAT_LO) begin
                n_c[i] = t_coord'(SAT_LO);
            end else begin
                n_c[i] = t_coord'(n_sum[i]);
            end
        end
    end

    // Zero the point on a miss
    always_ff @(posedge i_clk) begin
        o_hit  <= r_hit2;
        o_pt.x <= r_hit2 ? n_c[0] : '0;
        o_pt.y <= r_hit2 ? n_c[1] : '0;
        o_pt.z <= r_hit2 ? n_c[2] : '0;
    end
endmodule
`default_nettype wire

[design/ray_plane_intersect.sv]
`timescale 1ns / 1ps
`default_nettype none
// Ray/plane intersection, signed Q16.16.
// Pipeline from start to o_valid: 4 dot-product stages,
// 32 divider stages at one quotient bit each, 3 hit-point stages.
// Throughput: one request per cycle; busy is never raised.
// Reset clears only the valid bits; results are never held off.
module ray_plane_intersect (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [31:0]          i_ray_start_x,
    input  wire logic [31:0]          i_ray_start_y,
    input  wire logic [31:0]          i_ray_start_z,
    input  wire logic [31:0]          i_ray_dir_x,
    input  wire logic [31:0]          i_ray_dir_y,
    input  wire logic [31:0]          i_ray_dir_z,
    input  wire logic [31:0]          i_plane_pt_x,
    input  wire logic [31:0]          i_plane_pt_y,
    input  wire logic [31:0]          i_plane_pt_z,
    input  wire logic [31:0]          i_plane_norm_x,
    input  wire logic [31:0]          i_plane_norm_y,
    input  wire logic [31:0]          i_plane_norm_z,
    output logic                      o_valid,
    output logic                      o_hit,
    output logic [31:0]               o_hit_x,
    output logic [31:0]               o_hit_y,
    output logic [31:0]               o_hit_z
);
    import rpi_pkg::*;

    t_vec3            w_s, w_d, w_p, w_n, w_pt;
    logic             w_vld_dot, w_vld_div;
    t_side            w_side_dot, w_side_div;
    logic [DEN_W-1:0] w_dmag;
    logic [NMAG_W-1:0] w_nmag;
    logic [CW-1:0]    w_q;

    assign busy = 1'b0;

    assign w_s = '{x: i_ray_start_x, y: i_ray_start_y, z: i_ray_start_z};
    assign w_d = '{x: i_ray_dir_x, y: i_ray_dir_y, z: i_ray_dir_z};
    assign w_p = '{x: i_plane_pt_x, y: i_plane_pt_y, z: i_plane_pt_z};
    assign w_n = '{x: i_plane_norm_x, y: i_plane_norm_y, z: i_plane_norm_z};

    rpi_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_s     (w_s),
        .i_d     (w_d),
        .i_p     (w_p),
        .i_n     (w_n),
        .o_vld   (w_vld_dot),
        .o_side  (w_side_dot),
        .o_dmag  (w_dmag),
        .o_nmag  (w_nmag)
    );

    rpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld_dot),
        .i_side  (w_side_dot),
        .i_dmag  (w_dmag),
        .i_nmag  (w_nmag),
        .o_vld   (w_vld_div),
        .o_side  (w_side_div),
        .o_q     (w_q)
    );

    rpi_point u_point (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld_div),
        .i_side  (w_side_div),
        .i_q     (w_q),
        .o_vld   (o_valid),
        .o_hit   (o_hit),
        .o_pt    (w_pt)
    );

    assign o_hit_x = w_pt.x;
    assign o_hit_y = w_pt.y;
    assign o_hit_z = w_pt.z;
endmodule
`default_nettype wire
